>>> src/ale_pkg.sv
// ale_pkg: shared types and constants for the array list engine.
// Holds opcode, status, sequencer state and walk-kind encodings; no dependencies.
`timescale 1ns / 1ps

package ale_pkg;

	localparam int DEF_CAPACITY = 1024;
	localparam int VALUE_W      = 32;
	localparam int POS_W        = 16;
	localparam int FIDX_OUT_W   = 10;
	localparam int COUNT_OUT_W  = 11;

	typedef enum logic [2:0] {
		OP_APPEND       = 3'd0,
		OP_PREPEND      = 3'd1,
		OP_INSERT_AT    = 3'd2,
		OP_REMOVE_FIRST = 3'd3,
		OP_REMOVE_AT    = 3'd4,
		OP_SEARCH       = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_PLACE,
		S_DONE
	} state_t;

	// what the walk does with each word it reads
	typedef enum logic [1:0] {
		K_SHIFT_UP,
		K_SHIFT_DN,
		K_SEARCH
	} walk_t;

endpackage

>>> src/ale_store.sv
// ale_store: single-port-write, single-port-read entry memory with registered read.
// Uses ale_pkg for the word width.
`timescale 1ns / 1ps

module ale_store
	import ale_pkg::*;
#(
	parameter int DEPTH = DEF_CAPACITY,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [VALUE_W-1:0] wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output logic [VALUE_W-1:0] rdata
);

	logic [VALUE_W-1:0] mem [DEPTH];
	logic [VALUE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/array_list_engine.sv
// array_list_engine: ordered list of 32-bit values with insert, remove and search.
// Uses ale_pkg and ale_store (entry memory).
`timescale 1ns / 1ps

// One word in gives one word out. The list lives in a single memory with one
// write and one registered read port; a sequencer walks it one entry per cycle,
// moving each entry by one place (insert, remove) or comparing it (search).
// An insert at index p walks the entries from p to the end of the list, a removal
// at p those above p, a search the list up to the first match; a refused or
// unknown opcode skips the walk. Every entry that shifts costs one read and one
// write, and the write of one entry overlaps the read of the next. No new word
// is taken while one is being worked on; a finished result waits in the output
// register while the next word runs.

module array_list_engine
	import ale_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [2:0]                opcode,
	input  logic signed [VALUE_W-1:0] value,
	input  logic signed [POS_W-1:0]   position,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                status,
	output logic                      found,
	output logic [FIDX_OUT_W-1:0]     found_index,
	output logic [COUNT_OUT_W-1:0]    count
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	// common width for comparing a clamped position against the count
	localparam int PW    = (CNT_W > POS_W - 1) ? CNT_W : POS_W - 1;

	state_t state_q, state_d;

	logic [CNT_W-1:0]   count_q;
	logic               pend_q;
	logic               out_valid_q;

	walk_t              kind_q;
	logic [VALUE_W-1:0] value_q;
	logic [IDX_W-1:0]   where_q;
	logic [CNT_W-1:0]   left_q;
	logic [IDX_W-1:0]   ra_q;
	logic [IDX_W-1:0]   tag_q;
	status_t            status_q;
	logic               found_q;
	logic [IDX_W-1:0]   fidx_q;

	status_t            status_out_q;
	logic               found_out_q;
	logic [IDX_W-1:0]   fidx_out_q;
	logic [CNT_W-1:0]   count_out_q;

	logic               ram_we, ram_re;
	logic [IDX_W-1:0]   ram_waddr;
	logic [VALUE_W-1:0] ram_wdata, rd_data;

	logic               accept, hit, walk_end, out_load;

	// clamp and plan on accept
	logic [PW-1:0]      upos_w, cnt_w;
	logic               is_full, is_empty;
	logic [CNT_W-1:0]   ins_where, rem_where, cnt_m1;
	logic [CNT_W-1:0]   plan_where, plan_left;
	logic [IDX_W-1:0]   plan_ra;
	walk_t              plan_kind;
	status_t            plan_status;
	logic               plan_walk;

	ale_store #(
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ra_q),
		.rdata(rd_data)
	);

	always_comb begin
		upos_w   = position[POS_W-1] ? '0 : PW'(position[POS_W-2:0]);
		cnt_w    = PW'(count_q);
		is_full  = (count_q == CNT_W'(CAPACITY));
		is_empty = (count_q == '0);
		cnt_m1   = count_q - CNT_W'(1);
		ins_where = (upos_w > cnt_w) ? count_q : CNT_W'(upos_w);
		rem_where = (upos_w >= cnt_w) ? cnt_m1 : CNT_W'(upos_w);

		plan_where  = '0;
		plan_left   = '0;
		plan_ra     = '0;
		plan_kind   = K_SEARCH;
		plan_status = ST_DONE;
		plan_walk   = 1'b0;
		case (opcode)
			OP_APPEND, OP_PREPEND, OP_INSERT_AT: begin
				if (opcode == OP_APPEND) begin
					plan_where = count_q;
				end else if (opcode == OP_INSERT_AT) begin
					plan_where = ins_where;
				end
				plan_left   = count_q - plan_where;
				plan_ra     = IDX_W'(cnt_m1);
				plan_kind   = K_SHIFT_UP;
				plan_status = is_full ? ST_FULL : ST_DONE;
				plan_walk   = !is_full;
			end
			OP_REMOVE_FIRST, OP_REMOVE_AT: begin
				if (opcode == OP_REMOVE_AT) begin
					plan_where = rem_where;
				end
				plan_left   = cnt_m1 - plan_where;
				plan_ra     = IDX_W'(plan_where + CNT_W'(1));
				plan_kind   = K_SHIFT_DN;
				plan_status = is_empty ? ST_EMPTY : ST_DONE;
				plan_walk   = !is_empty;
			end
			OP_SEARCH: begin
				plan_left = count_q;
				plan_walk = 1'b1;
			end
			default: begin
				plan_walk = 1'b0;
			end
		endcase
	end

	assign accept   = (state_q == S_IDLE) && in_valid;
	assign hit      = (state_q == S_WALK) && pend_q && (kind_q == K_SEARCH)
		&& (rd_data == value_q);
	assign walk_end = (state_q == S_WALK) && !hit && (left_q == '0) && !pend_q;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = plan_walk ? S_WALK : S_DONE;
				end
			end
			S_WALK: begin
				if (hit) begin
					state_d = S_DONE;
				end else if (walk_end) begin
					state_d = (kind_q == K_SHIFT_UP) ? S_PLACE : S_DONE;
				end
			end
			S_PLACE: state_d = S_DONE;
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs and memory control
	always_comb begin
		in_ready  = (state_q == S_IDLE);
		ram_re    = (state_q == S_WALK) && (left_q != '0) && !hit;
		ram_we    = 1'b0;
		ram_waddr = (kind_q == K_SHIFT_UP) ? tag_q + IDX_W'(1) : tag_q - IDX_W'(1);
		ram_wdata = rd_data;
		case (state_q)
			S_WALK: ram_we = pend_q && (kind_q != K_SEARCH);
			S_PLACE: begin
				ram_we    = 1'b1;
				ram_waddr = where_q;
				ram_wdata = value_q;
			end
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= ram_re;
			if ((state_q == S_PLACE) || (walk_end && (kind_q == K_SHIFT_DN))) begin
				count_q <= (state_q == S_PLACE) ? count_q + CNT_W'(1) : count_q - CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= plan_kind;
			value_q  <= value;
			where_q  <= IDX_W'(plan_where);
			left_q   <= plan_left;
			ra_q     <= plan_ra;
			status_q <= plan_status;
			found_q  <= 1'b0;
			fidx_q   <= '0;
		end
		if (ram_re) begin
			tag_q  <= ra_q;
			left_q <= left_q - CNT_W'(1);
			ra_q   <= (kind_q == K_SHIFT_UP) ? ra_q - IDX_W'(1) : ra_q + IDX_W'(1);
		end
		if (hit) begin
			found_q <= 1'b1;
			fidx_q  <= tag_q;
		end
		if (out_load) begin
			status_out_q <= status_q;
			found_out_q  <= found_q;
			fidx_out_q   <= fidx_q;
			count_out_q  <= count_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_out_q;
	assign found       = found_out_q;
	assign found_index = FIDX_OUT_W'(fidx_out_q);
	assign count       = COUNT_OUT_W'(count_out_q);

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// testbench: directed, long-list and random list traffic for array_list_engine; every
// result word is checked against a queue-based model of the list. Needs ale_pkg and the RTL.

module testbench;
	import ale_pkg::*;

	localparam int LIST_CAP = DEF_CAPACITY;
	// depth the long-list test builds up before draining
	localparam int FILL_DEPTH = 100;
	// longest op walks the whole list, plus handshake stalls on top
	localparam int STALL_LIMIT = 20000;
	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;

	typedef struct {
		status_t                st;
		logic                   hit;
		logic [FIDX_OUT_W-1:0]  hit_index;
		logic [COUNT_OUT_W-1:0] size;
	} list_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [2:0]                opcode;
	logic signed [VALUE_W-1:0] value;
	logic signed [POS_W-1:0]   position;
	logic                      out_valid;
	logic                      out_ready;
	logic [1:0]                status;
	logic                      found;
	logic [FIDX_OUT_W-1:0]     found_index;
	logic [COUNT_OUT_W-1:0]    count;

	logic signed [VALUE_W-1:0] list_q[$];
	list_result_t              result_q[$];
	int                        mismatch_count = 0;
	int                        stall_cycles = 0;
	int                        send_idle_pct = 0;
	int                        recv_idle_pct = 0;

	array_list_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.value(value),
		.position(position),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.found(found),
		.found_index(found_index),
		.count(count)
	);

	always #5 clk = ~clk;

	// list model: applies one op and returns the result word it should give
	function automatic list_result_t predict_list_op(input logic [2:0] op,
			input logic signed [VALUE_W-1:0] val, input logic signed [POS_W-1:0] pos);
		list_result_t res;
		int where;
		int size;
		size = list_q.size();
		where = (pos < 0) ? 0 : int'(pos);
		res.st = ST_DONE;
		res.hit = 1'b0;
		res.hit_index = '0;
		case (op)
			OP_APPEND, OP_PREPEND, OP_INSERT_AT: begin
				if (size >= LIST_CAP) begin
					res.st = ST_FULL;
				end else begin
					if (op == OP_APPEND) where = size;
					else if (op == OP_PREPEND) where = 0;
					else if (where > size) where = size;
					if (where == size) list_q.push_back(val);
					else list_q.insert(where, val);
				end
			end
			OP_REMOVE_FIRST, OP_REMOVE_AT: begin
				if (size == 0) begin
					res.st = ST_EMPTY;
				end else begin
					if (op == OP_REMOVE_FIRST) where = 0;
					else if (where >= size) where = size - 1;
					list_q.delete(where);
				end
			end
			OP_SEARCH: begin
				for (int i = 0; i < size; i++) begin
					if (list_q[i] == val) begin
						res.hit = 1'b1;
						res.hit_index = FIDX_OUT_W'(i);
						break;
					end
				end
			end
			default: ;
		endcase
		res.size = COUNT_OUT_W'(list_q.size());
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		mismatch_count++;
	endtask

	// called right after a rising edge; returns in the step where the word was taken
	task automatic send_word(input logic [2:0] op, input logic signed [VALUE_W-1:0] val,
			input logic signed [POS_W-1:0] pos);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		value <= val;
		position <= pos;
		do @(posedge clk); while (!in_ready);
		result_q.push_back(predict_list_op(op, val, pos));
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_value(input logic [2:0] op);
		int r;
		r = $urandom_range(99);
		if (list_q.size() != 0 && r < ((op == OP_SEARCH) ? 60 : 25))
			return list_q[$urandom_range(list_q.size() - 1)];
		if (r > 94)
			return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
		return $urandom;
	endfunction

	function automatic logic signed [POS_W-1:0] pick_position();
		int r;
		int size;
		r = $urandom_range(99);
		size = list_q.size();
		if (r < 60) return POS_W'($urandom_range(size));
		else if (r < 75) return POS_W'($urandom_range(32768, 65535));
		else if (r < 90) return POS_W'($urandom_range(32767, size));
		return POS_W'($urandom);
	endfunction

	task automatic test_directed_edges();
		send_idle_pct = 14;
		recv_idle_pct = 80;
		// removal and search on an empty list
		send_word(OP_REMOVE_FIRST, 32'sd0, 16'sd0);
		send_word(OP_REMOVE_AT, 32'sd0, 16'sd0);
		send_word(OP_SEARCH, 32'sd0, 16'sd0);
		send_word(OP_APPEND, 32'sh7fffffff, 16'sd0);
		send_word(OP_PREPEND, 32'sh80000000, 16'sh7fff);
		// insert positions clamped from below and above
		send_word(OP_INSERT_AT, 32'sd5, 16'sh8000);
		send_word(OP_INSERT_AT, 32'sd7, 16'sh7fff);
		send_word(OP_INSERT_AT, 32'sd5, 16'sd2);
		send_word(OP_APPEND, 32'sd0, 16'sd0);
		send_word(OP_APPEND, 32'shffffffff, 16'shffff);
		// duplicate 5 must report the first index
		send_word(OP_SEARCH, 32'sd5, 16'sd0);
		send_word(OP_SEARCH, 32'sh7fffffff, 16'sd0);
		send_word(OP_SEARCH, 32'sd12345, 16'sd0);
		send_word(OP_SEARCH, 32'shffffffff, 16'sd0);
		send_word(OP_SPARE_6, 32'shffffffff, 16'shffff);
		send_word(OP_SPARE_7, 32'sh80000000, 16'sh8000);
		// remove positions clamped from below and above
		send_word(OP_REMOVE_AT, 32'sd0, 16'sh8000);
		send_word(OP_REMOVE_AT, 32'sd0, 16'sh7fff);
		send_word(OP_REMOVE_AT, 32'sd0, 16'sd1);
		send_word(OP_REMOVE_FIRST, 32'sd0, 16'sd0);
		send_word(OP_REMOVE_AT, 32'sd0, 16'sd3);
		send_word(OP_REMOVE_FIRST, 32'sd0, 16'sd0);
		send_word(OP_REMOVE_AT, 32'sd0, 16'sd0);
		send_word(OP_REMOVE_AT, 32'sd0, 16'sd0);
	endtask

	task automatic test_long_list();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		// unique values so the last entry is found at the top index
		while (list_q.size() < FILL_DEPTH)
			send_word(OP_APPEND, (list_q.size() << 20) | $urandom_range(20'hfffff), 16'sd0);
		send_word(OP_SEARCH, list_q[FILL_DEPTH - 1], 16'sd0);
		send_word(OP_SEARCH, list_q[0], 16'sd0);
		send_word(OP_PREPEND, $urandom, 16'sd0);
		send_word(OP_INSERT_AT, $urandom, 16'sd5);
		send_word(OP_REMOVE_FIRST, 32'sd0, 16'sd0);
		send_word(OP_REMOVE_AT, 32'sd0, 16'sd7);
		while (list_q.size() != 0)
			send_word(OP_REMOVE_AT, 32'sd0, 16'sh7fff);
	endtask

	task automatic test_random_traffic(input int n_items, input int send_pct, input int recv_pct);
		int done_items;
		int total;
		int target;
		int r;
		logic [2:0] op;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		done_items = 0;
		total = 0;
		target = 8;
		while (done_items < n_items) begin
			// list size drifts toward a target: mostly short lists, sometimes long
			if (total % 40 == 0)
				target = ($urandom_range(3) == 0) ? $urandom_range(300, 100) : $urandom_range(24);
			total++;
			r = $urandom_range(99);
			if (r < 5) begin
				send_word(r[0] ? OP_SPARE_6 : OP_SPARE_7, $urandom, POS_W'($urandom));
			end else begin
				if (r < 30) begin
					op = OP_SEARCH;
				end else if ((list_q.size() < target) ? (r < 75) : (r < 45)) begin
					case ($urandom_range(2))
						0: op = OP_APPEND;
						1: op = OP_PREPEND;
						default: op = OP_INSERT_AT;
					endcase
				end else begin
					op = $urandom_range(1) ? OP_REMOVE_FIRST : OP_REMOVE_AT;
				end
				send_word(op, pick_value(op), pick_position());
				done_items++;
			end
		end
	endtask

	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : check_results
		list_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (result_q.size() == 0) begin
				report_mismatch($sformatf("result word with nothing pending, count %0d", count));
			end else begin
				want = result_q.pop_front();
				if (status !== want.st)
					report_mismatch($sformatf("status %0d, want %0d", status, want.st));
				if (found !== want.hit)
					report_mismatch($sformatf("found %0b, want %0b", found, want.hit));
				if (found_index !== want.hit_index)
					report_mismatch($sformatf("found_index %0d, want %0d",
						found_index, want.hit_index));
				if (count !== want.size)
					report_mismatch($sformatf("count %0d, want %0d", count, want.size));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("array_list_engine verification failed");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		opcode <= OP_APPEND;
		value <= '0;
		position <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_random_traffic(120, 14, 80);
		test_random_traffic(120, 80, 14);
		test_long_list();
		test_random_traffic(100, 0, 0);
		in_valid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("array_list_engine verification clean");
		else
			$display("array_list_engine verification failed");
		$finish;
	end

endmodule
